[hw/rtl/hisim_pkg.sv]
// Package for the histogram intersection similarity core.
// Holds field widths, count mask and the structs passed between modules.
// No dependencies.
package hisim_pkg;

   localparam int unsigned CountBits = 16;
   localparam int unsigned AccBits   = 25;
   localparam int unsigned SimBits   = 17;
   localparam int unsigned FracBits  = 16;
   localparam int unsigned QuotSteps = FracBits + 1;
   localparam int unsigned StepBits  = $clog2(QuotSteps);

   localparam logic [CountBits-1:0] CountMask = '1;
   localparam logic [AccBits-1:0]   AccMax    = '1;
   localparam logic [SimBits-1:0]   SimOne    = SimBits'(1) << FracBits;

   typedef logic [CountBits-1:0] count_type;
   typedef logic [AccBits-1:0]   acc_type;
   typedef logic [SimBits-1:0]   sim_type;

   typedef struct packed {
      acc_type overlap;
      acc_type total_a;
      acc_type total_b;
   } sums_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

[hw/rtl/hisim_if.sv]
// Request and response channel interfaces with valid/ready handshake.
// Depends on hisim_pkg.
interface hisim_req_if;
   import hisim_pkg::*;

   logic      valid;
   logic      ready;
   count_type bin_a;
   count_type bin_b;
   logic      last_bin;

   modport source (output valid, output bin_a, output bin_b, output last_bin, input ready);
   modport sink   (input valid, input bin_a, input bin_b, input last_bin, output ready);
endinterface

interface hisim_rsp_if;
   import hisim_pkg::*;

   logic    valid;
   logic    ready;
   sim_type similarity;
   acc_type overlap_sum;
   acc_type total_a;
   acc_type total_b;
   logic    empty_total;

   modport source (output valid, output similarity, output overlap_sum, output total_a,
                   output total_b, output empty_total, input ready);
   modport sink   (input valid, input similarity, input overlap_sum, input total_a,
                   input total_b, input empty_total, output ready);
endinterface

[hw/rtl/hisim_acc.sv]
// Saturating accumulators for the overlap sum and both histogram totals.
// Depends on hisim_pkg.
module hisim_acc (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 last_bin,
   input  hisim_pkg::count_type bin_a,
   input  hisim_pkg::count_type bin_b,
   output hisim_pkg::sums_type  sums_next
);
   import hisim_pkg::*;

   count_type a_m;
   count_type b_m;
   count_type min_ab;
   sums_type  acc_ff;
   sums_type  acc_in;

   function automatic acc_type sat_add(acc_type acc, count_type v);
      logic [AccBits:0] s;
      s = {1'b0, acc} + (AccBits+1)'(v);
      return s[AccBits] ? AccMax : s[AccBits-1:0];
   endfunction

   assign a_m    = bin_a & CountMask;
   assign b_m    = bin_b & CountMask;
   assign min_ab = (a_m < b_m) ? a_m : b_m;

   assign sums_next.overlap = sat_add(acc_ff.overlap, min_ab);
   assign sums_next.total_a = sat_add(acc_ff.total_a, a_m);
   assign sums_next.total_b = sat_add(acc_ff.total_b, b_m);

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         acc_in = last_bin ? '0 : sums_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[hw/rtl/hisim_div.sv]
// Iterative restoring divider: one compare/subtract per cycle, 17 quotient bits.
// Computes floor(dividend * 2^16 / divisor) for dividend <= divisor. Depends on hisim_pkg.
module hisim_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  hisim_pkg::acc_type      dividend,
   input  hisim_pkg::acc_type      divisor,
   output hisim_pkg::sim_type      quotient,
   output hisim_pkg::div_stat_type stat
);
   import hisim_pkg::*;

   logic [AccBits:0]  rem_ff, rem_in;
   acc_type           dvs_ff, dvs_in;
   sim_type           quot_ff, quot_in;
   logic [StepBits-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [AccBits:0]  trial;
   logic              ge;

   assign trial = (cnt_ff == '0) ? rem_ff : {rem_ff[AccBits-1:0], 1'b0};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, dividend};
         dvs_in  = divisor;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (trial - {1'b0, dvs_ff}) : trial;
         quot_in = {quot_ff[SimBits-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == StepBits'(QuotSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign quotient  = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

[hw/rtl/histogram_intersection_similarity_core.sv]
// Histogram intersection similarity core: top level with sequencer and result register.
// Depends on hisim_pkg, hisim_if, hisim_acc and hisim_div.
//
//   channel   direction   handshake       payload
//   req_ch    in          valid/ready     bin_a, bin_b, last_bin
//   rsp_ch    out         valid/ready     similarity, overlap_sum, total_a, total_b, empty_total
//
// A last bin is accepted and then takes 17 steps of the compare/subtract divider; the
// quotient is handed over and the result register is loaded once it is free. An empty
// total skips the divider.
// req_ch.ready is low while the divider runs or a finished result waits for the result register.
// Synchronous reset clears the sequencer, accumulators and result valid.
module histogram_intersection_similarity_core (
   input logic           clock,
   input logic           reset,
   hisim_req_if.sink     req_ch,
   hisim_rsp_if.source   rsp_ch
);
   import hisim_pkg::*;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StSend = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic         accept;
   sums_type     sums_next;
   sums_type     hold_ff, hold_in;
   logic         empty_ff, empty_in;
   acc_type      min_total;
   logic         div_start;
   sim_type      quotient;
   div_stat_type div_stat;
   logic         load;

   logic         rsp_valid_ff, rsp_valid_in;
   sim_type      rsp_sim_ff, rsp_sim_in;
   sums_type     rsp_sums_ff, rsp_sums_in;
   logic         rsp_empty_ff, rsp_empty_in;

   assign req_ch.ready = (state_ff == StIdle);
   assign accept       = req_ch.valid && req_ch.ready;

   hisim_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .last_bin  (req_ch.last_bin),
      .bin_a     (req_ch.bin_a),
      .bin_b     (req_ch.bin_b),
      .sums_next (sums_next)
   );

   assign min_total = (sums_next.total_a < sums_next.total_b) ? sums_next.total_a
                                                              : sums_next.total_b;
   assign div_start = accept && req_ch.last_bin && (min_total != '0);

   hisim_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_next.overlap),
      .divisor  (min_total),
      .quotient (quotient),
      .stat     (div_stat)
   );

   assign load = (state_ff == StSend) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_sim_in   = rsp_sim_ff;
      rsp_sums_in  = rsp_sums_ff;
      rsp_empty_in = rsp_empty_ff;
      case (state_ff)
         StIdle: begin
            if (accept && req_ch.last_bin) begin
               hold_in  = sums_next;
               empty_in = (min_total == '0);
               state_in = (min_total == '0) ? StSend : StDiv;
            end
         end
         StDiv: begin
            if (div_stat.done) begin
               state_in = StSend;
            end
         end
         StSend: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_sim_in   = empty_ff ? '0 : ((quotient > SimOne) ? SimOne : quotient);
               rsp_sums_in  = hold_ff;
               rsp_empty_in = empty_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff      <= hold_in;
      empty_ff     <= empty_in;
      rsp_sim_ff   <= rsp_sim_in;
      rsp_sums_ff  <= rsp_sums_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.similarity  = rsp_sim_ff;
   assign rsp_ch.overlap_sum = rsp_sums_ff.overlap;
   assign rsp_ch.total_a     = rsp_sums_ff.total_a;
   assign rsp_ch.total_b     = rsp_sums_ff.total_b;
   assign rsp_ch.empty_total = rsp_empty_ff;

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !div_stat.busy)
      else $error("request taken while divider busy");

   a_div_done_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StDiv) && div_stat.done |=> (state_ff == StSend))
      else $error("divider result not forwarded");

   a_sim_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sim_ff <= SimOne))
      else $error("similarity above one");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> (rsp_sim_ff == '0))
      else $error("empty total with nonzero similarity");

   a_overlap_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sums_ff.overlap <= rsp_sums_ff.total_a)
                       && (rsp_sums_ff.overlap <= rsp_sums_ff.total_b))
      else $error("overlap exceeds a total");

endmodule

[test/histogram_intersection_similarity_core_test.sv]
// Self-checking testbench for histogram_intersection_similarity_core: streams bin-pair
// requests, predicts the overlap, totals and Q1.16 similarity, and checks every response.
// Depends on hisim_pkg, hisim_if and the core RTL.
module histogram_intersection_similarity_core_test;
   import hisim_pkg::*;

   localparam int NumItems     = 1150;
   localparam int CycleLimit   = 200000;
   localparam int HoldAt       = 250;
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 40;
   localparam int QuietFrom    = 3000;
   localparam int QuietTo      = 4500;
   localparam int IdlePercent  = 20;

   typedef enum int {
      FILL_FULL,
      FILL_SPARSE,
      FILL_ONE_SIDED,
      FILL_EQUAL,
      FILL_HEAVY
   } fill_mode_type;

   typedef struct packed {
      count_type bin_a;
      count_type bin_b;
      logic      last_bin;
      logic      drain_first;
   } bin_pair_type;

   typedef struct packed {
      sim_type similarity;
      acc_type overlap_sum;
      acc_type total_a;
      acc_type total_b;
      logic    empty_total;
   } score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hisim_req_if req_ch ();
   hisim_rsp_if rsp_ch ();

   histogram_intersection_similarity_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   bin_pair_type pending_bins[$];
   score_type    expected_scores[$];

   acc_type overlap_run;
   acc_type total_a_run;
   acc_type total_b_run;

   int cycle_count = 0;
   int req_count   = 0;
   int failures    = 0;
   int items_added = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   bit req_fired   = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit idle_now();
      if (cycle_count >= QuietFrom && cycle_count < QuietTo) begin
         return 1'b0;
      end
      return $urandom_range(99) < IdlePercent;
   endfunction

   function automatic acc_type sat_sum(acc_type acc, count_type value);
      logic [AccBits:0] sum;
      sum = {1'b0, acc} + (AccBits+1)'(value);
      return sum[AccBits] ? AccMax : sum[AccBits-1:0];
   endfunction

   task automatic accumulate_bin(bin_pair_type pair);
      count_type       smaller_bin;
      acc_type         smaller_total;
      longint unsigned quotient;
      score_type       score;
      smaller_bin = (pair.bin_a < pair.bin_b) ? pair.bin_a : pair.bin_b;
      overlap_run = sat_sum(overlap_run, smaller_bin);
      total_a_run = sat_sum(total_a_run, pair.bin_a);
      total_b_run = sat_sum(total_b_run, pair.bin_b);
      if (pair.last_bin) begin
         smaller_total = (total_a_run < total_b_run) ? total_a_run : total_b_run;
         score.overlap_sum = overlap_run;
         score.total_a     = total_a_run;
         score.total_b     = total_b_run;
         if (smaller_total == '0) begin
            score.similarity  = '0;
            score.empty_total = 1'b1;
         end else begin
            quotient = (longint'(overlap_run) << FracBits) / longint'(smaller_total);
            if (quotient > longint'(SimOne)) begin
               quotient = longint'(SimOne);
            end
            score.similarity  = sim_type'(quotient);
            score.empty_total = 1'b0;
         end
         expected_scores = {expected_scores, score};
         overlap_run = '0;
         total_a_run = '0;
         total_b_run = '0;
      end
   endtask

   task automatic add_bin(int a, int b, bit last_bin, bit drain_first = 1'b0);
      bin_pair_type pair;
      pair.bin_a       = count_type'(a);
      pair.bin_b       = count_type'(b);
      pair.last_bin    = last_bin;
      pair.drain_first = drain_first;
      pending_bins     = {pending_bins, pair};
      items_added++;
   endtask

   task automatic add_histogram(int len, fill_mode_type mode, bit drain_first = 1'b0);
      int a;
      int b;
      bit zero_a;
      zero_a = $urandom_range(1);
      for (int i = 0; i < len; i++) begin
         a = $urandom_range(65535);
         b = $urandom_range(65535);
         case (mode)
            FILL_SPARSE: begin
               a = $urandom_range(3);
               b = $urandom_range(3);
            end
            FILL_ONE_SIDED: begin
               if (zero_a) a = 0;
               else b = 0;
            end
            FILL_EQUAL: begin
               b = a;
            end
            FILL_HEAVY: begin
               a = $urandom_range(65535, 61440);
               b = $urandom_range(65535, 61440);
            end
            default: begin
            end
         endcase
         add_bin(a, b, i == len - 1, drain_first && i == 0);
      end
   endtask

   always @(negedge clock) begin : drive_bins
      bin_pair_type next_pair;
      bit           offer;
      if (!reset && !(req_ch.valid && !req_fired)) begin
         offer = 1'b0;
         if (pending_bins.size() > 0 && !idle_now()) begin
            if (!(pending_bins[0].drain_first && expected_scores.size() > 0)) begin
               next_pair = pending_bins.pop_front();
               offer     = 1'b1;
            end
         end
         req_ch.valid <= offer;
         if (offer) begin
            req_ch.bin_a    <= next_pair.bin_a;
            req_ch.bin_b    <= next_pair.bin_b;
            req_ch.last_bin <= next_pair.last_bin;
         end
         req_fired = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (!hold_done && req_count >= HoldAt) begin
         hold_left = HoldCycles;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !idle_now();
      end
   end

   always @(posedge clock) begin : watch_channels
      score_type want;
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_fired = 1'b1;
            req_count++;
            accumulate_bin({req_ch.bin_a, req_ch.bin_b, req_ch.last_bin, 1'b0});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_scores.size() == 0) begin
               $error("response with no request pending: similarity %0d",
                      rsp_ch.similarity);
               failures++;
            end else begin
               want = expected_scores.pop_front();
               if (rsp_ch.similarity !== want.similarity) begin
                  $error("similarity: expected %0d, got %0d",
                         want.similarity, rsp_ch.similarity);
                  failures++;
               end
               if (rsp_ch.overlap_sum !== want.overlap_sum) begin
                  $error("overlap_sum: expected %0d, got %0d",
                         want.overlap_sum, rsp_ch.overlap_sum);
                  failures++;
               end
               if (rsp_ch.total_a !== want.total_a) begin
                  $error("total_a: expected %0d, got %0d", want.total_a, rsp_ch.total_a);
                  failures++;
               end
               if (rsp_ch.total_b !== want.total_b) begin
                  $error("total_b: expected %0d, got %0d", want.total_b, rsp_ch.total_b);
                  failures++;
               end
               if (rsp_ch.empty_total !== want.empty_total) begin
                  $error("empty_total: expected %0d, got %0d",
                         want.empty_total, rsp_ch.empty_total);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      bit sat_done;
      int len;
      req_ch.valid    = 1'b0;
      req_ch.bin_a    = '0;
      req_ch.bin_b    = '0;
      req_ch.last_bin = 1'b0;
      rsp_ch.ready    = 1'b0;
      overlap_run     = '0;
      total_a_run     = '0;
      total_b_run     = '0;
      sat_done        = 1'b0;

      add_bin(0, 0, 1'b1);
      add_bin(16'hFFFF, 16'hFFFF, 1'b1);
      add_bin(0, 16'hFFFF, 1'b1);
      add_bin(16'hFFFF, 0, 1'b1);
      add_bin(16'h8000, 16'h1234, 1'b0);
      add_bin(16'h0001, 16'hFFFF, 1'b1);
      add_bin(16'hAAAA, 16'h5555, 1'b0);
      add_bin(16'h5555, 16'hAAAA, 1'b1);
      add_bin(1, 3, 1'b1);
      add_bin(2, 3, 1'b0);
      add_bin(1, 0, 1'b1);
      add_bin(0, 0, 1'b0);
      add_bin(0, 0, 1'b0);
      add_bin(7, 0, 1'b1);
      add_bin(16'hFFFF, 1, 1'b0);
      add_bin(1, 16'hFFFF, 1'b0);
      add_bin(0, 0, 1'b1);
      add_bin(0, 1, 1'b0);
      add_bin(3, 0, 1'b1);

      add_histogram(3, FILL_FULL, 1'b1);
      while (items_added < NumItems) begin
         if (!sat_done && items_added >= 400) begin
            add_histogram(560, FILL_HEAVY, 1'b1);
            sat_done = 1'b1;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            add_histogram(len, fill_mode_type'($urandom_range(FILL_HEAVY, FILL_FULL)));
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_bins.size() > 0 || req_ch.valid) @(posedge clock);
      while (expected_scores.size() > 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
